// File: rtl/ptq_pkg.sv
// Package: shared types and constants of the periodic timer queue.
`default_nettype none
package ptq_pkg;
   localparam int TIMER_SLOTS = 16;
   localparam int MAX_FIRES_PER_TICK = 63;
   localparam int SLOT_W = $clog2(TIMER_SLOTS);
   localparam int FIRE_W = $clog2(MAX_FIRES_PER_TICK + 1);
   localparam logic [47:0] DEADLINE_MAX = 48'hFFFF_FFFF_FFFF;
   localparam logic [30:0] EMPTY_TIMEOUT = 31'h4000_0000;

   typedef enum logic [1:0] {
      ACT_SCHEDULE = 2'd0,
      ACT_CANCEL   = 2'd1,
      ACT_TICK     = 2'd2,
      ACT_SHUTDOWN = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_SCHEDULED = 3'd0,
      ST_CANCELLED = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_REFUSED   = 3'd3,
      ST_FULL      = 3'd4,
      ST_FIRED     = 3'd5,
      ST_DONE      = 3'd6
   } status_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [47:0] now_ms;
      logic [47:0] deadline_ms;
      logic [31:0] period_ms;
      logic [31:0] handle_seq;
      logic        handle_periodic;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] timer_seq;
      logic [47:0] timer_deadline;
      logic        timer_periodic;
      logic [30:0] next_timeout_ms;
      logic        last;
   } rsp_type;
endpackage
`default_nettype wire

// File: rtl/ptq_if.sv
// Interface: valid/ready channel carrying one packed payload.
`default_nettype none
interface ptq_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/periodic_timer_queue.sv
// Top level: timer table with a sequencer that scans one slot per cycle.
//
// Channel | Dir | Payload
// req     | in  | ptq_pkg::req_type (action, times, handle)
// rsp     | out | ptq_pkg::rsp_type (status, handle, timeout, last)
//
// Every action scans the table one slot per cycle through one shared
// compare unit: schedule, cancel and shutdown pass from one req transfer to
// the next through idle, scan, act and done.
// A tick goes through act, rescan start and a full scan per firing.
// reset clears the valid bits, the sequence counter and the shutdown flag.
// A stalled result holds the sequencer; req is ready only when idle.
`default_nettype none
module periodic_timer_queue (
   input wire logic clock,
   input wire logic reset,
   ptq_if.sink      req,
   ptq_if.source    rsp
);
   import ptq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_ACT, S_EMIT, S_DONE
   } state_type;

   state_type state_ff;
   req_type req_ff;
   rsp_type rsp_ff;
   logic rsp_valid_ff;
   logic [SLOT_W:0] idx_ff;
   logic found_ff;
   logic [SLOT_W-1:0] best_ff;
   logic [47:0] best_dl_ff;
   logic [31:0] best_ord_ff;
   logic [FIRE_W-1:0] fires_ff;
   logic [31:0] seq_ff;
   logic shut_ff;
   logic [TIMER_SLOTS-1:0] valid_ff;

   logic        mem_per [TIMER_SLOTS];
   logic [47:0] mem_dl  [TIMER_SLOTS];
   logic [31:0] mem_prd [TIMER_SLOTS];
   logic [31:0] mem_hs  [TIMER_SLOTS];
   logic [31:0] mem_ord [TIMER_SLOTS];

   logic [SLOT_W-1:0] cur;
   logic cur_valid, cur_match, cur_better;
   logic [48:0] rearm_sum;
   logic [48:0] diff;

   assign cur = idx_ff[SLOT_W-1:0];
   assign cur_valid = valid_ff[cur];
   assign cur_match = cur_valid && mem_per[cur] == req_ff.handle_periodic &&
                      mem_hs[cur] == req_ff.handle_seq &&
                      (req_ff.handle_periodic || mem_dl[cur] == req_ff.deadline_ms);
   assign cur_better = !found_ff || mem_dl[cur] < best_dl_ff ||
                       (mem_dl[cur] == best_dl_ff && mem_ord[cur] < best_ord_ff);
   assign rearm_sum = {1'b0, mem_dl[best_ff]} + {17'd0, mem_prd[best_ff]};
   assign diff = {1'b0, best_dl_ff} - {1'b0, req_ff.now_ms};

   assign req.ready = state_ff == S_IDLE;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_ff;

   always_ff @(posedge clock) begin
      rsp_type rsp_in;
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff <= '0;
         seq_ff <= '0;
         shut_ff <= 1'b0;
         fires_ff <= '0;
      end else begin
         if (rsp.valid && rsp.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  req_ff <= req.data;
                  idx_ff <= '0;
                  found_ff <= 1'b0;
                  fires_ff <= '0;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               // Schedule looks for the lowest free slot, cancel for the first match,
               // tick for the earliest deadline; a deadline tie goes to the lower order value.
               if (idx_ff < (SLOT_W+1)'(TIMER_SLOTS)) begin
                  unique case (action_type'(req_ff.action))
                     ACT_SCHEDULE: if (!cur_valid && !found_ff) begin
                        found_ff <= 1'b1;
                        best_ff <= cur;
                     end
                     ACT_CANCEL: if (cur_match && !found_ff) begin
                        found_ff <= 1'b1;
                        best_ff <= cur;
                     end
                     ACT_TICK: if (cur_valid && cur_better) begin
                        found_ff <= 1'b1;
                        best_ff <= cur;
                        best_dl_ff <= mem_dl[cur];
                        best_ord_ff <= mem_ord[cur];
                     end
                     default: ;
                  endcase
                  idx_ff <= idx_ff + 1'b1;
               end else begin
                  state_ff <= S_ACT;
               end
            end
            S_ACT: begin
               if (!rsp_valid_ff) begin
                  rsp_in = '0;
                  rsp_in.last = 1'b1;
                  rsp_valid_ff <= 1'b1;
                  unique case (action_type'(req_ff.action))
                     ACT_SCHEDULE: begin
                        state_ff <= S_DONE;
                        if (shut_ff) rsp_in.status = ST_REFUSED;
                        else if (!found_ff) rsp_in.status = ST_FULL;
                        else begin
                           valid_ff[best_ff] <= 1'b1;
                           mem_per[best_ff] <= req_ff.period_ms != '0;
                           mem_dl[best_ff] <= req_ff.deadline_ms;
                           mem_prd[best_ff] <= req_ff.period_ms;
                           mem_hs[best_ff] <= seq_ff + 32'd1;
                           if (req_ff.period_ms != '0) begin
                              mem_ord[best_ff] <= seq_ff + 32'd2;
                              seq_ff <= seq_ff + 32'd2;
                              rsp_in.timer_periodic = 1'b1;
                           end else begin
                              mem_ord[best_ff] <= seq_ff + 32'd1;
                              seq_ff <= seq_ff + 32'd1;
                              rsp_in.timer_deadline = req_ff.deadline_ms;
                           end
                           rsp_in.status = ST_SCHEDULED;
                           rsp_in.timer_seq = seq_ff + 32'd1;
                        end
                     end
                     ACT_CANCEL: begin
                        state_ff <= S_DONE;
                        if (found_ff) valid_ff[best_ff] <= 1'b0;
                        rsp_in.status = found_ff ? ST_CANCELLED : ST_NOT_FOUND;
                     end
                     ACT_SHUTDOWN: begin
                        state_ff <= S_DONE;
                        valid_ff <= '0;
                        shut_ff <= 1'b1;
                        rsp_in.status = ST_DONE;
                     end
                     ACT_TICK: begin
                        if (found_ff && best_dl_ff <= req_ff.now_ms &&
                            fires_ff != FIRE_W'(MAX_FIRES_PER_TICK)) begin
                           rsp_in.status = ST_FIRED;
                           rsp_in.last = 1'b0;
                           rsp_in.timer_seq = mem_hs[best_ff];
                           if (mem_per[best_ff]) begin
                              mem_dl[best_ff] <= rearm_sum[48] ? DEADLINE_MAX
                                                               : rearm_sum[47:0];
                              mem_ord[best_ff] <= seq_ff + 32'd1;
                              seq_ff <= seq_ff + 32'd1;
                              rsp_in.timer_periodic = 1'b1;
                           end else begin
                              valid_ff[best_ff] <= 1'b0;
                              rsp_in.timer_deadline = best_dl_ff;
                           end
                           fires_ff <= fires_ff + 1'b1;
                           state_ff <= S_EMIT;
                        end else begin
                           state_ff <= S_DONE;
                           rsp_in.status = ST_DONE;
                           if (!found_ff) rsp_in.next_timeout_ms = EMPTY_TIMEOUT;
                           else if (diff[48] || diff == '0)
                              rsp_in.next_timeout_ms = '0;
                           else if (diff[47:0] > 48'(EMPTY_TIMEOUT))
                              rsp_in.next_timeout_ms = EMPTY_TIMEOUT;
                           else rsp_in.next_timeout_ms = diff[30:0];
                        end
                     end
                     default: state_ff <= S_DONE;
                  endcase
                  rsp_ff <= rsp_in;
               end
            end
            S_EMIT: begin
               // Rescan for the next firing.
               idx_ff <= '0;
               found_ff <= 1'b0;
               state_ff <= S_SCAN;
            end
            S_DONE: begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_fire_cap: assert property (@(posedge clock) disable iff (reset)
      fires_ff <= FIRE_W'(MAX_FIRES_PER_TICK)) else $error("fire cap exceeded");
   a_shut_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && shut_ff) |-> valid_ff == '0)
      else $error("table not empty after shutdown");
endmodule
`default_nettype wire
